FILE: rtl/pqit_pkg.sv
// Shared types and constants for the pending query id table.
// Used by the table core and the port checker.
package pqit_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int TAG_BITS      = 32;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  // removed count tracks up to the full table, reported saturated to 5 bits
  localparam int RM_W  = (CNT_W > 5) ? CNT_W : 5;

  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int OUTTAG_W = 32;
  localparam int MARGIN_W = 16;
  localparam int CTR_W    = 32;
  localparam int REMOUT_W = 5;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam int S_DATA_W = ID_W + OUTTAG_W + TIME_W;
  localparam int M_DATA_RAW_W = OUTTAG_W + REMOUT_W + 2 * CTR_W;
  localparam int M_DATA_W = ((M_DATA_RAW_W + 7) / 8) * 8;
  localparam int PADDR_W  = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DONE  = 3'd5;

  // Register index of expiry_margin
  localparam logic REG_MARGIN = 1'b0;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd30;

  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [TAG_BITS-1:0] tag;
    logic [ID_W-1:0]     id;
  } entry_t;

endpackage

FILE: rtl/pqit_ram.sv
// Simple dual-port synchronous RAM with a registered read.
// Generic; holds the table entries for the core.
module pqit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pending_query_id_table_core.sv
// Pending query id table: top level with FSM, valid bits, counters, config port.
// Depends on pqit_pkg and pqit_ram.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+----------------------------------
//  s_*       | in        | s_tvalid / s_tready    | cmd (tuser), id/tag/now (tdata)
//  m_*       | out       | m_tvalid / m_tready    | status (tuser), results (tdata)
//  APB       | in        | psel&penable&pwrite    | expiry_margin at byte address 0
//
// Each command walks every table entry through the entry RAM, one read per
// cycle from its single registered read port. One command is in flight at a
// time; the next input is taken while a result waits in the output register.
// A stalled output holds the finish step until the slot frees.
// Reset (rst, synchronous) clears all valid bits, both counters and the margin
// to 30; the entry RAM needs no clearing since valid bits gate every read.
module pending_query_id_table_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [15:0] query_id, [47:16] client_tag, [79:48] now_time
  input  logic [pqit_pkg::S_DATA_W-1:0]        s_tdata,
  // [1:0] cmd
  input  logic [pqit_pkg::CMD_W-1:0]           s_tuser,
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [31:0] found_tag, [36:32] removed_count, [68:37] duplicate_total,
  // [100:69] expired_total, [103:101] zero
  output logic [pqit_pkg::M_DATA_W-1:0]        m_tdata,
  // [2:0] status
  output logic [pqit_pkg::STATUS_W-1:0]        m_tuser,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pqit_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int N  = pqit_pkg::TABLE_ENTRIES;
  localparam int IW = pqit_pkg::IDX_W;
  localparam int RW = pqit_pkg::RM_W;

  logic [1:0]                        state;
  logic [pqit_pkg::CMD_W-1:0]        cmd_q;
  logic [pqit_pkg::ID_W-1:0]         id_q;
  logic [pqit_pkg::TAG_BITS-1:0]     tag_q;
  logic [pqit_pkg::TIME_W-1:0]       now_q;
  logic [IW:0]                       rd_idx;   // next read address, reaches N
  logic                              chk_vld;  // RAM data valid this cycle
  logic [IW-1:0]                     chk_idx;  // entry that RAM data belongs to
  logic [N-1:0]                      valid;
  logic                              hit;
  logic [pqit_pkg::OUTTAG_W-1:0]     hit_tag;
  logic                              free_found;
  logic [IW-1:0]                     free_idx;
  logic [RW-1:0]                     rem_cnt;
  logic [pqit_pkg::CTR_W-1:0]        dup_total;
  logic [pqit_pkg::CTR_W-1:0]        exp_total;
  logic [pqit_pkg::MARGIN_W-1:0]     margin;

  logic                              accept;
  logic                              rd_en;
  logic                              out_free;
  logic                              fin_go;
  logic                              ram_we;
  logic                              ent_v;
  logic                              ent_hit;
  logic                              ent_old;
  logic [pqit_pkg::TIME_W:0]         exp_sum;
  logic [pqit_pkg::TIME_W-1:0]       exp_val;
  logic [pqit_pkg::CTR_W-1:0]        dup_next;
  logic [pqit_pkg::STATUS_W-1:0]     status_next;
  logic [pqit_pkg::REMOUT_W-1:0]     rem_out;
  pqit_pkg::entry_t                  rd_ent;
  pqit_pkg::entry_t                  wr_ent;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign rd_en    = (state == S_SCAN) && (rd_idx < (IW+1)'(N));
  assign out_free = !m_tvalid || m_tready;
  assign fin_go   = (state == S_FIN) && out_free;

  // per-entry checks on the word coming back from the RAM
  assign ent_v   = chk_vld && valid[chk_idx];
  assign ent_hit = ent_v && (rd_ent.id == id_q);
  assign ent_old = ent_v && (now_q > rd_ent.expiry);

  // saturating expiry
  assign exp_sum = {1'b0, now_q} + (pqit_pkg::TIME_W+1)'(margin);
  assign exp_val = exp_sum[pqit_pkg::TIME_W] ? '1 : exp_sum[pqit_pkg::TIME_W-1:0];

  assign ram_we        = fin_go && (cmd_q == pqit_pkg::CMD_ADD) && !hit && free_found;
  assign wr_ent.expiry = exp_val;
  assign wr_ent.tag    = tag_q;
  assign wr_ent.id     = id_q;

  pqit_ram #(
    .WIDTH ($bits(pqit_pkg::entry_t)),
    .DEPTH (N),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rd_ent)
  );

  // finish-step result
  always_comb begin
    dup_next    = dup_total;
    status_next = pqit_pkg::STAT_DONE;
    unique case (cmd_q)
      pqit_pkg::CMD_ADD: begin
        if (hit) begin
          dup_next    = dup_total + 1'b1;
          status_next = pqit_pkg::STAT_DUP;
        end else if (free_found) begin
          status_next = pqit_pkg::STAT_ADDED;
        end else begin
          status_next = pqit_pkg::STAT_FULL;
        end
      end
      pqit_pkg::CMD_LOOKUP: begin
        status_next = hit ? pqit_pkg::STAT_FOUND : pqit_pkg::STAT_MISS;
      end
      default: begin
        status_next = pqit_pkg::STAT_DONE;
      end
    endcase
  end

  assign rem_out = (rem_cnt > RW'(31)) ? 5'd31 : rem_cnt[pqit_pkg::REMOUT_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_vld   <= 1'b0;
      rd_idx    <= '0;
      valid     <= '0;
      dup_total <= '0;
      exp_total <= '0;
      margin    <= pqit_pkg::MARGIN_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == pqit_pkg::REG_MARGIN)) begin
        margin <= pwdata[pqit_pkg::MARGIN_W-1:0];
      end
      // output slot: loaded by the finish step, freed by a result transfer
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state   <= S_SCAN;
            rd_idx  <= '0;
            chk_vld <= 1'b0;
          end
        end
        S_SCAN: begin
          chk_vld <= rd_en;
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (chk_vld) begin
            if ((cmd_q == pqit_pkg::CMD_SWEEP && ent_old) ||
                (cmd_q == pqit_pkg::CMD_FLUSH && ent_v)) begin
              valid[chk_idx] <= 1'b0;
            end
            if (cmd_q == pqit_pkg::CMD_SWEEP && ent_old) begin
              exp_total <= exp_total + 1'b1;
            end
          end
          // last entry checked this cycle
          if (!rd_en && chk_vld) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state     <= S_IDLE;
            dup_total <= dup_next;
            if (ram_we) begin
              valid[free_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= s_tuser;
      id_q       <= s_tdata[15:0];
      tag_q      <= pqit_pkg::TAG_BITS'(s_tdata[47:16]);
      now_q      <= s_tdata[79:48];
      hit        <= 1'b0;
      free_found <= 1'b0;
      rem_cnt    <= '0;
    end
    if (state == S_SCAN) begin
      chk_idx <= rd_idx[IW-1:0];
      if (chk_vld) begin
        if (ent_hit && (cmd_q == pqit_pkg::CMD_ADD || cmd_q == pqit_pkg::CMD_LOOKUP)) begin
          hit     <= 1'b1;
          hit_tag <= pqit_pkg::OUTTAG_W'(rd_ent.tag);
        end
        if (cmd_q == pqit_pkg::CMD_ADD && !valid[chk_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if ((cmd_q == pqit_pkg::CMD_SWEEP && ent_old) ||
            (cmd_q == pqit_pkg::CMD_FLUSH && ent_v)) begin
          rem_cnt <= rem_cnt + 1'b1;
        end
      end
    end
    if (fin_go) begin
      m_tuser <= status_next;
      m_tdata <= pqit_pkg::M_DATA_W'({
                   exp_total,
                   dup_next,
                   ((cmd_q == pqit_pkg::CMD_SWEEP || cmd_q == pqit_pkg::CMD_FLUSH)
                      ? rem_out : 5'd0),
                   ((cmd_q == pqit_pkg::CMD_LOOKUP && hit) ? hit_tag : 32'd0)
                 });
    end
  end

  // register readback
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pqit_pkg::REG_MARGIN) ? 32'(margin) : 32'd0;

endmodule

FILE: rtl/pqit_checker.sv
// Port-level checker for the pending query id table, bound to the core.
// Depends on pqit_pkg.
module pqit_port_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pqit_pkg::M_DATA_W-1:0]     m_tdata,
  input logic [pqit_pkg::STATUS_W-1:0]     m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // found_tag only on a found lookup
  a_tag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != pqit_pkg::STAT_FOUND) |-> (m_tdata[31:0] == 32'd0))
    else $error("found_tag nonzero without a hit");

  // removed_count only on sweep or flush
  a_rem: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != pqit_pkg::STAT_DONE) |-> (m_tdata[36:32] == 5'd0))
    else $error("removed_count nonzero outside sweep or flush");

  // duplicate counter steps by one on a duplicate result right after a transfer
  a_dup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready ##1 m_tvalid && !$past(rst) && (m_tuser == pqit_pkg::STAT_DUP)
      |-> (m_tdata[68:37] == $past(m_tdata[68:37]) + 32'd1))
    else $error("duplicate_total did not step on duplicate");

endmodule

bind pending_query_id_table_core pqit_port_props u_pqit_port_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
